### sv/mi3_pkg.sv
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// ---------------------------------------------------------------------------
package mi3_pkg;

   localparam int ENTRY_WIDTH       = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;

   typedef struct packed {
      entry_type c0_r0;
      entry_type c0_r1;
      entry_type c0_r2;
      entry_type c1_r0;
      entry_type c1_r1;
      entry_type c1_r2;
      entry_type c2_r0;
      entry_type c2_r1;
      entry_type c2_r2;
   } req_type;

   typedef struct packed {
      entry_type i0_r0;
      entry_type i0_r1;
      entry_type i0_r2;
      entry_type i1_r0;
      entry_type i1_r1;
      entry_type i1_r2;
      entry_type i2_r0;
      entry_type i2_r1;
      entry_type i2_r2;
      logic      singular;
      logic      clipped;
   } rsp_type;

endpackage

### sv/matrix3x3_inverse.sv
// Throughput: one matrix per cycle while the response is not stalled; the quotient is built by one restoring
// divide stage per result bit, nine lanes wide, so every stage takes a new item.
// A stalled response freezes the whole pipeline and the request side stalls with it.
// Reset (synchronous, active high) clears all stage valid bits; data registers keep
// whatever they hold.
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// Adjugate-method 3x3 inverse with exact cofactors and determinant, a
// pipelined rounding divide, and saturation to the entry range.
// ---------------------------------------------------------------------------
module matrix3x3_inverse #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mi3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mi3_pkg::rsp_type rsp_data
);
   import mi3_pkg::*;

   localparam int E   = ENTRY_WIDTH;
   localparam int CW  = 2*E + 1;
   localparam int DW  = 3*E + 3;
   localparam int W   = 4*E + 2*FRAC_BITS + 6;
   localparam int LAT = E + 10;
   localparam logic [E-1:0] LIM_NEG = {1'b1, {(E-1){1'b0}}};
   localparam logic [E-1:0] LIM_POS = {1'b0, {(E-1){1'b1}}};

   logic en;
   logic vld_ff [1:LAT];

   // Stage 1: input matrix, m[col][row].
   logic signed [E-1:0]    m1_ff  [0:2][0:2];
   // Stage 2: cofactor products.
   logic signed [2*E-1:0]  p2_ff  [0:2][0:2];
   logic signed [2*E-1:0]  s2_ff  [0:2][0:2];
   logic signed [E-1:0]    x2_ff  [0:2];
   // Stage 3: cofactors, cof[row][j].
   logic signed [CW-1:0]   cof3_ff [0:2][0:2];
   logic signed [E-1:0]    x3_ff  [0:2];
   // Stage 4: determinant partial products.
   logic signed [2*E:0]    plo4_ff [0:2];
   logic signed [2*E:0]    phi4_ff [0:2];
   logic signed [CW-1:0]   cof4_ff [0:2][0:2];
   // Stage 5: determinant terms.
   logic signed [3*E:0]    t5_ff  [0:2];
   logic signed [CW-1:0]   cof5_ff [0:2][0:2];
   // Stage 6: determinant.
   logic signed [DW-1:0]   det6_ff;
   logic signed [CW-1:0]   cof6_ff [0:2][0:2];
   // Stage 7: magnitudes and signs, lane = row*3 + col.
   logic [DW-1:0]          dabs7_ff;
   logic [2*E-1:0]         cabs7_ff [0:8];
   logic                   neg7_ff  [0:8];
   logic                   sing7_ff;
   // Stage 8: rounded numerator and doubled divisor.
   logic [W-1:0]           num8_ff  [0:8];
   logic [W-1:0]           dd8_ff;
   logic                   neg8_ff  [0:8];
   logic                   sing8_ff;
   // Divide stages 0..E.
   logic [W-1:0]           rem_ff  [0:E][0:8];
   logic [E-1:0]           q_ff    [0:E][0:8];
   logic                   neg_ff  [0:E][0:8];
   logic                   ovf_ff  [0:E][0:8];
   logic [W-1:0]           dd_ff   [0:E];
   logic                   sing_ff [0:E];
   // Output register.
   rsp_type                rsp_ff;

   logic signed [2*E-1:0]  p2_in  [0:2][0:2];
   logic signed [2*E-1:0]  s2_in  [0:2][0:2];
   logic signed [2*E:0]    plo4_in [0:2];
   logic signed [2*E:0]    phi4_in [0:2];
   logic signed [3*E:0]    t5_in  [0:2];
   logic [DW-1:0]          dabs7_in;
   logic [2*E-1:0]         cabs7_in [0:8];
   logic                   neg7_in  [0:8];
   logic [W-1:0]           num8_in  [0:8];
   logic [W-1:0]           rem_in  [1:E][0:8];
   logic [E-1:0]           q_in    [1:E][0:8];
   logic [E-1:0]           res_in  [0:8];
   logic                   clip_in;
   logic [W-1:0]           trial;
   logic [E-1:0]           q;

   // The pipeline moves as one unit unless a finished transaction is held.
   assign en        = !(vld_ff[LAT] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Row r of the inverse is the cross product of columns r+1 and r+2.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            p2_in[r][j] = (2*E)'(m1_ff[(r+1)%3][(j+1)%3]) * (2*E)'(m1_ff[(r+2)%3][(j+2)%3]);
            s2_in[r][j] = (2*E)'(m1_ff[(r+1)%3][(j+2)%3]) * (2*E)'(m1_ff[(r+2)%3][(j+1)%3]);
         end
      end
      // Cofactor split into an unsigned low word and a signed high part.
      for (int k = 0; k < 3; k++) begin
         plo4_in[k] = (2*E+1)'(x3_ff[k])
                    * $signed({1'b0, E'(cof3_ff[0][k][E-1:0])});
         phi4_in[k] = (2*E+1)'(x3_ff[k]) * (2*E+1)'($signed(cof3_ff[0][k][CW-1:E]));
         t5_in[k]   = ((3*E+1)'(phi4_ff[k]) <<< E) + (3*E+1)'(plo4_ff[k]);
      end
      dabs7_in = det6_ff[DW-1] ? DW'(-det6_ff) : DW'(det6_ff);
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            cabs7_in[r*3+j] = cof6_ff[r][j][CW-1] ? (2*E)'(-cof6_ff[r][j])
                                                  : (2*E)'(cof6_ff[r][j]);
            neg7_in[r*3+j]  = cof6_ff[r][j][CW-1] ^ det6_ff[DW-1];
         end
      end
      // Adding |D| before dividing by 2|D| rounds half away from zero.
      for (int l = 0; l < 9; l++) begin
         num8_in[l] = (W'(cabs7_ff[l]) << (2*FRAC_BITS + 1)) + W'(dabs7_ff);
      end
      for (int s = 0; s < E; s++) begin
         for (int l = 0; l < 9; l++) begin
            trial = dd_ff[s] << (E - 1 - s);
            q_in[s+1][l] = q_ff[s][l];
            if (rem_ff[s][l] >= trial) begin
               rem_in[s+1][l] = rem_ff[s][l] - trial;
               q_in[s+1][l][E-1-s] = 1'b1;
            end else begin
               rem_in[s+1][l] = rem_ff[s][l];
            end
         end
      end
      clip_in = 1'b0;
      for (int l = 0; l < 9; l++) begin
         q = q_ff[E][l];
         if (sing_ff[E]) begin
            res_in[l] = '0;
         end else if (neg_ff[E][l]) begin
            if (ovf_ff[E][l] || q > LIM_NEG) begin
               res_in[l] = LIM_NEG;
               clip_in   = 1'b1;
            end else begin
               res_in[l] = E'(-q);
            end
         end else begin
            if (ovf_ff[E][l] || q[E-1]) begin
               res_in[l] = LIM_POS;
               clip_in   = 1'b1;
            end else begin
               res_in[l] = q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff[0][0] <= req_data.c0_r0;
         m1_ff[0][1] <= req_data.c0_r1;
         m1_ff[0][2] <= req_data.c0_r2;
         m1_ff[1][0] <= req_data.c1_r0;
         m1_ff[1][1] <= req_data.c1_r1;
         m1_ff[1][2] <= req_data.c1_r2;
         m1_ff[2][0] <= req_data.c2_r0;
         m1_ff[2][1] <= req_data.c2_r1;
         m1_ff[2][2] <= req_data.c2_r2;
         for (int k = 0; k < 3; k++) begin
            x2_ff[k]   <= m1_ff[0][k];
            x3_ff[k]   <= x2_ff[k];
            plo4_ff[k] <= plo4_in[k];
            phi4_ff[k] <= phi4_in[k];
            t5_ff[k]   <= t5_in[k];
         end
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               p2_ff[r][j]   <= p2_in[r][j];
               s2_ff[r][j]   <= s2_in[r][j];
               cof3_ff[r][j] <= CW'(p2_ff[r][j]) - CW'(s2_ff[r][j]);
               cof4_ff[r][j] <= cof3_ff[r][j];
               cof5_ff[r][j] <= cof4_ff[r][j];
               cof6_ff[r][j] <= cof5_ff[r][j];
            end
         end
         det6_ff  <= DW'(t5_ff[0]) + DW'(t5_ff[1]) + DW'(t5_ff[2]);
         dabs7_ff <= dabs7_in;
         sing7_ff <= (det6_ff == '0);
         dd8_ff   <= W'(dabs7_ff) << 1;
         sing8_ff <= sing7_ff;
         for (int l = 0; l < 9; l++) begin
            cabs7_ff[l] <= cabs7_in[l];
            neg7_ff[l]  <= neg7_in[l];
            num8_ff[l]  <= num8_in[l];
            neg8_ff[l]  <= neg7_ff[l];
            // A quotient of 2^E or more saturates whatever its low bits are.
            rem_ff[0][l] <= num8_ff[l];
            q_ff[0][l]   <= '0;
            neg_ff[0][l] <= neg8_ff[l];
            ovf_ff[0][l] <= (num8_ff[l] >= (dd8_ff << E));
         end
         dd_ff[0]   <= dd8_ff;
         sing_ff[0] <= sing8_ff;
         for (int s = 1; s <= E; s++) begin
            dd_ff[s]   <= dd_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
            for (int l = 0; l < 9; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               q_ff[s][l]   <= q_in[s][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
               ovf_ff[s][l] <= ovf_ff[s-1][l];
            end
         end
         // Inverse column c, row r comes from cofactor lane r*3 + c.
         rsp_ff.i0_r0    <= res_in[0];
         rsp_ff.i0_r1    <= res_in[3];
         rsp_ff.i0_r2    <= res_in[6];
         rsp_ff.i1_r0    <= res_in[1];
         rsp_ff.i1_r1    <= res_in[4];
         rsp_ff.i1_r2    <= res_in[7];
         rsp_ff.i2_r0    <= res_in[2];
         rsp_ff.i2_r1    <= res_in[5];
         rsp_ff.i2_r2    <= res_in[8];
         rsp_ff.singular <= sing_ff[E];
         rsp_ff.clipped  <= clip_in;
      end
   end

   // A singular matrix gives an all-zero, unclipped result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> !rsp_data.clipped && rsp_data.i0_r0 == '0
         && rsp_data.i1_r1 == '0 && rsp_data.i2_r2 == '0)
      else $error("singular result carries nonzero data");

   // A clipped result has at least one entry at a range limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.i0_r0 == LIM_POS || rsp_data.i0_r0 == LIM_NEG ||
         rsp_data.i0_r1 == LIM_POS || rsp_data.i0_r1 == LIM_NEG ||
         rsp_data.i0_r2 == LIM_POS || rsp_data.i0_r2 == LIM_NEG ||
         rsp_data.i1_r0 == LIM_POS || rsp_data.i1_r0 == LIM_NEG ||
         rsp_data.i1_r1 == LIM_POS || rsp_data.i1_r1 == LIM_NEG ||
         rsp_data.i1_r2 == LIM_POS || rsp_data.i1_r2 == LIM_NEG ||
         rsp_data.i2_r0 == LIM_POS || rsp_data.i2_r0 == LIM_NEG ||
         rsp_data.i2_r1 == LIM_POS || rsp_data.i2_r1 == LIM_NEG ||
         rsp_data.i2_r2 == LIM_POS || rsp_data.i2_r2 == LIM_NEG)
      else $error("clipped flag without a saturated entry");

   // The request side stalls exactly when a finished transaction is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall out of step with response");

endmodule

### tb/mi3_checker.sv
// ---------------------------------------------------------------------------
// mi3_checker
// Watches both channels of the 3x3 inverse, computes the rounded, saturated inverse of
// each accepted matrix and compares it field by field with the responses.
// ---------------------------------------------------------------------------
module mi3_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mi3_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mi3_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending
);
   import mi3_pkg::*;

   localparam int FB = FRAC_BITS_DEFAULT;

   rsp_type inverse_queue[$];

   // Round to nearest, ties away from zero, then clamp to the entry range.
   function automatic entry_type scale_entry(input logic signed [255:0] cof,
                                             input logic signed [255:0] det,
                                             inout logic clip);
      logic [255:0] num, dabs, q;
      logic neg;
      logic [255:0] lim;
      begin
         neg  = cof[255] ^ det[255];
         num  = cof[255] ? -cof : cof;
         dabs = det[255] ? -det : det;
         q    = ((num << (2 * FB + 1)) + dabs) / (dabs << 1);
         if (q == 0) neg = 0;
         lim = neg ? (256'd1 << (ENTRY_WIDTH - 1)) : ((256'd1 << (ENTRY_WIDTH - 1)) - 1);
         if (q > lim) begin
            q    = lim;
            clip = 1;
         end
         return neg ? entry_type'(-q) : entry_type'(q);
      end
   endfunction

   function automatic rsp_type invert(input req_type m);
      logic signed [255:0] cof [3][3], det;
      logic signed [255:0] cols [3][3];
      entry_type e [3][3];
      rsp_type r;
      logic clip;
      int a, b;
      begin
         cols[0][0] = m.c0_r0; cols[0][1] = m.c0_r1; cols[0][2] = m.c0_r2;
         cols[1][0] = m.c1_r0; cols[1][1] = m.c1_r1; cols[1][2] = m.c1_r2;
         cols[2][0] = m.c2_r0; cols[2][1] = m.c2_r1; cols[2][2] = m.c2_r2;
         for (int row = 0; row < 3; row++) begin
            a = (row + 1) % 3;
            b = (row + 2) % 3;
            cof[row][0] = cols[a][1] * cols[b][2] - cols[a][2] * cols[b][1];
            cof[row][1] = cols[a][2] * cols[b][0] - cols[a][0] * cols[b][2];
            cof[row][2] = cols[a][0] * cols[b][1] - cols[a][1] * cols[b][0];
         end
         det = cols[0][0] * cof[0][0] + cols[0][1] * cof[0][1] + cols[0][2] * cof[0][2];
         r = '0;
         if (det == 0) begin
            r.singular = 1;
            return r;
         end
         clip = 0;
         for (int c = 0; c < 3; c++)
            for (int rw = 0; rw < 3; rw++)
               e[c][rw] = scale_entry(cof[rw][c], det, clip);
         r.i0_r0 = e[0][0]; r.i0_r1 = e[0][1]; r.i0_r2 = e[0][2];
         r.i1_r0 = e[1][0]; r.i1_r1 = e[1][1]; r.i1_r2 = e[1][2];
         r.i2_r0 = e[2][0]; r.i2_r1 = e[2][1]; r.i2_r2 = e[2][2];
         r.clipped = clip;
         return r;
      end
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      begin
         if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
         end
      end
   endtask

   initial errors = 0;
   initial pending = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) inverse_queue.push_back(invert(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (inverse_queue.size() == 0) begin
               $error("response with no matrix outstanding");
               errors++;
            end else begin
               want = inverse_queue.pop_front();
               compare_field("i0_r0", want.i0_r0, rsp_data.i0_r0);
               compare_field("i0_r1", want.i0_r1, rsp_data.i0_r1);
               compare_field("i0_r2", want.i0_r2, rsp_data.i0_r2);
               compare_field("i1_r0", want.i1_r0, rsp_data.i1_r0);
               compare_field("i1_r1", want.i1_r1, rsp_data.i1_r1);
               compare_field("i1_r2", want.i1_r2, rsp_data.i1_r2);
               compare_field("i2_r0", want.i2_r0, rsp_data.i2_r0);
               compare_field("i2_r1", want.i2_r1, rsp_data.i2_r1);
               compare_field("i2_r2", want.i2_r2, rsp_data.i2_r2);
               compare_field("singular", want.singular, rsp_data.singular);
               compare_field("clipped", want.clipped, rsp_data.clipped);
            end
         end
      end
      pending = inverse_queue.size();
   end

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives directed and random matrices into the 3x3 inverse with random idle
// bursts on both sides and reports the verdict from the checker.
// ---------------------------------------------------------------------------
module tb;
   import mi3_pkg::*;

   localparam int ONE        = 32'h0001_0000;
   localparam int NUM_RANDOM = 1373;
   localparam int LATENCY    = ENTRY_WIDTH + 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   logic    quiet_phase;
   logic    long_hold;

   matrix3x3_inverse i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mi3_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic req_type diag_matrix(input entry_type a, input entry_type b,
                                           input entry_type c);
      req_type m;
      begin
         m = '0;
         m.c0_r0 = a;
         m.c1_r1 = b;
         m.c2_r2 = c;
         return m;
      end
   endfunction

   // Small entries give invertible matrices with in-range inverses most of the time.
   function automatic entry_type random_entry();
      case ($urandom_range(0, 9))
         0:       return entry_type'($urandom());
         1:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         2:       return 0;
         3, 4:    return entry_type'($signed($urandom_range(0, 8)) - 4) * ONE;
         default: return entry_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      begin
         m.c0_r0 = random_entry(); m.c0_r1 = random_entry(); m.c0_r2 = random_entry();
         m.c1_r0 = random_entry(); m.c1_r1 = random_entry(); m.c1_r2 = random_entry();
         m.c2_r0 = random_entry(); m.c2_r1 = random_entry(); m.c2_r2 = random_entry();
         // Now and then copy column 0 into column 2, in part or whole, so that singular matrices keep showing up.
         if ($urandom_range(0, 15) == 0) m.c2_r0 = m.c0_r0;
         if ($urandom_range(0, 15) == 0) begin
            m.c2_r1 = m.c0_r1;
            m.c2_r2 = m.c0_r2;
            m.c2_r0 = m.c0_r0;
         end
         return m;
      end
   endfunction

   task automatic send_matrix(input req_type m, input logic allow_gaps);
      int gap;
      begin
         if (allow_gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
            req_valid <= 0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1;
         req_data  <= m;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      begin
         req_valid <= 0;
         while (pending != 0) @(posedge clock);
      end
   endtask

   // Response side: random stall bursts, one long hold-off, and none at the end.
   initial begin
      int burst;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (150) @(posedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_stall <= 1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      req_type m;
      reset       = 1;
      req_valid   = 0;
      req_data    = '0;
      quiet_phase = 0;
      long_hold   = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed matrices: identity, scaled diagonals, singular, saturating, ties.
      send_matrix(diag_matrix(ONE, ONE, ONE), 0);
      send_matrix(diag_matrix(2 * ONE, -4 * ONE, ONE / 2), 0);
      send_matrix('0, 0);
      send_matrix(diag_matrix(1, 1, 1), 0);
      send_matrix(diag_matrix(-1, 1, -1), 0);
      send_matrix(diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff), 0);
      send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0);
      send_matrix(diag_matrix(32'sh8000_0000, 32'sh7fff_ffff, ONE), 0);
      send_matrix(diag_matrix(3 * ONE, 3 * ONE, 3 * ONE), 0);
      send_matrix(diag_matrix(ONE, ONE, 0), 0);
      send_matrix({9{32'sh7fff_ffff}}, 0);
      send_matrix({9{32'sh8000_0000}}, 0);
      send_matrix({9{32'shffff_ffff}}, 0);
      send_matrix({32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 32'shedcb_a987,
                   32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh0000_0001, 32'sh8000_0001,
                   32'sh7fff_fffe}, 0);
      m = diag_matrix(ONE, ONE, ONE);
      m.c1_r0 = 2 * ONE;
      m.c2_r0 = -3 * ONE;
      m.c2_r1 = ONE / 4;
      send_matrix(m, 0);
      // A power-of-two diagonal gives quotients that divide exactly; the next diagonal does not.
      send_matrix(diag_matrix(2 * 32'sh0002_0000, 32'sh0002_0000, 32'sh0008_0000), 0);
      send_matrix(diag_matrix(32'sh0002_0000 * 3, 32'sh0001_8000, 32'shfffe_0000), 0);

      // Long response hold while matrices keep arriving, so input backs up.
      long_hold = 1;
      for (int i = 0; i < 60; i++) send_matrix(random_matrix(), 0);
      drain_responses();

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM / 2) drain_responses();
         if (i == NUM_RANDOM - 200) quiet_phase = 1;
         send_matrix(random_matrix(), 1);
      end
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
sv/mi3_pkg.sv
sv/matrix3x3_inverse.sv
tb/mi3_checker.sv
tb/tb.sv
